>>> design/quoted_word_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// Quoted word tokenizer assertion macros
// Shared assertion helpers, sampled on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef QUOTED_WORD_TOKENIZER_DEFINES_SVH
`define QUOTED_WORD_TOKENIZER_DEFINES_SVH

// Checks that a property holds at every clock edge outside reset.
`define QWT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tokenizer check failed");

// Checks that a condition never occurs outside reset.
`define QWT_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("tokenizer forbidden condition seen");

`endif

>>> design/qwt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quoted word tokenizer package
// Character codes, register constants and the types shared by the tokenizer.
// ----------------------------------------------------------------------------
package qwt_pkg;

  localparam int unsigned CFG_W = 9;
  localparam int unsigned CFG_RESET = 256;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_HT   = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_HASH = 8'h23;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } qwt_kind_e;

  typedef struct packed {
    logic in_quoted;
    logic word_active;
    logic quote_pending;
    logic skip_rest;
  } qwt_flags_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_word_byte;
    logic       starts_word;
    logic       closed_word;
    logic       line_ended;
  } qwt_result_t;

endpackage
`default_nettype wire

>>> design/qwt_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quoted word tokenizer step logic
// Classifies one item against the current line state and gives the next
// state together with the result for that item.
// ----------------------------------------------------------------------------
module qwt_core #(
  parameter int unsigned LB_W = 9
) (
  input  qwt_pkg::qwt_kind_e  kind_i,
  input  logic [7:0]          data_byte_i,
  input  qwt_pkg::qwt_flags_t flags_i,
  input  logic [LB_W-1:0]     line_bytes_i,
  input  logic [LB_W-1:0]     limit_i,
  output qwt_pkg::qwt_flags_t flags_o,
  output logic [LB_W-1:0]     line_bytes_o,
  output qwt_pkg::qwt_result_t result_o
);
  import qwt_pkg::*;

  logic            quoted;
  logic            escaped;
  logic [LB_W-1:0] count;

  always_comb begin
    flags_o      = flags_i;
    line_bytes_o = line_bytes_i;
    result_o     = '0;
    quoted       = flags_i.in_quoted;
    escaped      = 1'b0;
    count        = line_bytes_i + LB_W'(1);

    if (kind_i == KIND_END) begin
      result_o.closed_word = flags_i.word_active;
      result_o.line_ended  = (line_bytes_i != '0);
      flags_o              = '0;
      line_bytes_o         = '0;
    end else if (data_byte_i == CH_CR || data_byte_i == CH_LF || data_byte_i == CH_FF) begin
      result_o.out_byte    = data_byte_i;
      result_o.closed_word = flags_i.word_active;
      result_o.line_ended  = 1'b1;
      flags_o              = '0;
      line_bytes_o         = '0;
    end else begin
      result_o.out_byte = data_byte_i;
      line_bytes_o      = count;
      if (!flags_i.skip_rest) begin
        if (flags_i.quote_pending) begin
          flags_o.quote_pending = 1'b0;
          if (data_byte_i == CH_DQ) begin
            escaped = 1'b1;
          end else begin
            quoted = !flags_i.in_quoted;
          end
        end
        flags_o.in_quoted = quoted;
        if (escaped) begin
          result_o.is_word_byte = 1'b1;
        end else if (data_byte_i == CH_NUL || (data_byte_i == CH_HASH && !quoted)) begin
          result_o.closed_word = flags_i.word_active;
          flags_o.word_active  = 1'b0;
          flags_o.skip_rest    = 1'b1;
        end else if ((data_byte_i == CH_SP || data_byte_i == CH_HT) && !quoted) begin
          result_o.closed_word = flags_i.word_active;
          flags_o.word_active  = 1'b0;
        end else begin
          result_o.starts_word  = !flags_i.word_active;
          flags_o.word_active   = 1'b1;
          result_o.is_word_byte = 1'b1;
          if (data_byte_i == CH_DQ) begin
            flags_o.quote_pending = 1'b1;
          end
        end
      end
      if (count >= limit_i) begin
        result_o.line_ended = 1'b1;
        flags_o             = '0;
        line_bytes_o        = '0;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/quoted_word_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quoted word tokenizer
// Splits a byte stream into lines and words, one result beat per input beat.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle unless the output is stalled and
// gives one result beat for each, passing it from the input register through
// the step logic into the output register, which also holds the line state.
// The line length limit is taken from the configuration register, with zero
// treated as one and values above LINE_LIMIT treated as LINE_LIMIT.
// Configuration writes are always ready and take effect on the next beat.
`include "quoted_word_tokenizer_defines.svh"

module quoted_word_tokenizer #(
  parameter int unsigned LINE_LIMIT = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [qwt_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // data_byte
  input  logic                     s_axis_tuser,   // kind
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata,   // out_byte
  output logic [2:0]               m_axis_tuser,   // is_word_byte, starts_word, closed_word
  output logic                     m_axis_tlast    // line_ended
);
  import qwt_pkg::*;

  localparam int unsigned LB_W = $clog2(LINE_LIMIT + 1);
  localparam int unsigned CMP_W = (LB_W > CFG_W) ? LB_W : CFG_W;
  localparam int unsigned RESET_LIMIT = (CFG_RESET > LINE_LIMIT) ? LINE_LIMIT : CFG_RESET;

  logic            in_valid_q;
  qwt_kind_e       in_kind_q;
  logic [7:0]      in_byte_q;
  logic            out_valid_q;
  qwt_result_t     out_q;
  qwt_flags_t      flags_q;
  qwt_flags_t      flags_d;
  logic [LB_W-1:0] line_bytes_q;
  logic [LB_W-1:0] line_bytes_d;
  logic [LB_W-1:0] limit_q;
  logic [LB_W-1:0] limit_d;
  qwt_result_t     result;
  logic            advance;
  logic            step;

  assign cfg_ready_o   = 1'b1;
  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    if (cfg_data_i == '0) begin
      limit_d = LB_W'(1);
    end else if (CMP_W'(cfg_data_i) > CMP_W'(LINE_LIMIT)) begin
      limit_d = LB_W'(LINE_LIMIT);
    end else begin
      limit_d = LB_W'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LB_W'(RESET_LIMIT);
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= limit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind_q <= qwt_kind_e'(s_axis_tuser);
      in_byte_q <= s_axis_tdata;
    end
  end

  qwt_core #(
    .LB_W (LB_W)
  ) u_core (
    .kind_i       (in_kind_q),
    .data_byte_i  (in_byte_q),
    .flags_i      (flags_q),
    .line_bytes_i (line_bytes_q),
    .limit_i      (limit_q),
    .flags_o      (flags_d),
    .line_bytes_o (line_bytes_d),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q      <= '0;
      line_bytes_q <= '0;
      out_valid_q  <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        flags_q      <= flags_d;
        line_bytes_q <= line_bytes_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_q.out_byte;
  assign m_axis_tuser[0] = out_q.is_word_byte;
  assign m_axis_tuser[1] = out_q.starts_word;
  assign m_axis_tuser[2] = out_q.closed_word;
  assign m_axis_tlast    = out_q.line_ended;

  `QWT_ASSERT(a_line_within_limit, line_bytes_q < LB_W'(LINE_LIMIT))
  `QWT_ASSERT(a_start_is_word, !m_axis_tvalid || !m_axis_tuser[1] || m_axis_tuser[0])
  `QWT_ASSERT_NEVER(a_start_and_close, m_axis_tvalid && m_axis_tuser[1] && m_axis_tuser[2])
  `QWT_ASSERT(a_line_end_clears, (step && result.line_ended) |=>
    (line_bytes_q == '0 && flags_q == '0))

endmodule
`default_nettype wire
